@@ rtl/lca_pkg.sv @@
// Shared types, constants and lookup functions for latency class accounting.
package lca_pkg;

  localparam int unsigned NumSlots = 5;
  localparam int unsigned SlotW = $clog2(NumSlots);
  localparam logic [SlotW-1:0] LastTestIdx = SlotW'(NumSlots - 1);

  localparam logic [19:0] NsPerMs = 20'd1000000;
  localparam int unsigned ThrW = 52;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgTracing = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSlowTotal = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSlowPhase = 2'd2;

  localparam logic [2:0] ClsUnknown = 3'd0;
  localparam logic [2:0] ClsRead = 3'd1;
  localparam logic [2:0] ClsActive = 3'd2;
  localparam logic [2:0] ClsDetail = 3'd3;
  localparam logic [2:0] ClsWrite = 3'd4;
  localparam logic [2:0] ClsQueue = 3'd5;
  localparam logic [2:0] ClsCache = 3'd6;
  localparam logic [2:0] ClsMixed = 3'd7;

  localparam logic [SlotW-1:0] SlotRead = 3'd0;
  localparam logic [SlotW-1:0] SlotActive = 3'd1;
  localparam logic [SlotW-1:0] SlotWrite = 3'd2;
  localparam logic [SlotW-1:0] SlotQueue = 3'd3;
  localparam logic [SlotW-1:0] SlotCache = 3'd4;

  typedef struct packed {
    logic [2:0]  span_class;
    logic [63:0] span_duration_ns;
    logic        span_present;
    logic [63:0] record_total_ns;
    logic        last_span;
  } in_t;

  typedef struct packed {
    logic [2:0]  dominant_class;
    logic [63:0] read_wait_sum_ns;
    logic [63:0] active_sum_ns;
    logic [63:0] write_sum_ns;
    logic [63:0] queue_sum_ns;
    logic [63:0] cache_sum_ns;
    logic        is_slow;
  } out_t;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_TEST,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic             accum;
    logic             capture_last;
    logic [SlotW-1:0] test_idx;
    logic             latch_dom;
    logic             load_out;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic total_zero;
  } sts_t;

  typedef struct packed {
    logic             summed;
    logic [SlotW-1:0] slot;
  } slot_sel_t;

  function automatic slot_sel_t slot_of_class(input logic [2:0] cls);
    slot_sel_t r;
    r = '{summed: 1'b1, slot: SlotRead};
    case (cls)
      ClsRead:   r.slot = SlotRead;
      ClsActive: r.slot = SlotActive;
      ClsWrite:  r.slot = SlotWrite;
      ClsQueue:  r.slot = SlotQueue;
      ClsCache:  r.slot = SlotCache;
      default:   r.summed = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [SlotW-1:0] order_slot(input logic [SlotW-1:0] idx);
    logic [SlotW-1:0] r;
    case (idx)
      3'd0:    r = SlotRead;
      3'd1:    r = SlotWrite;
      3'd2:    r = SlotActive;
      3'd3:    r = SlotQueue;
      default: r = SlotCache;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] order_class(input logic [SlotW-1:0] idx);
    logic [2:0] r;
    case (idx)
      3'd0:    r = ClsRead;
      3'd1:    r = ClsWrite;
      3'd2:    r = ClsActive;
      3'd3:    r = ClsQueue;
      default: r = ClsCache;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/lca_ctrl.sv @@
// Controller: accept, share-test sequencing and result transfer.
module lca_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  lca_pkg::sts_t sts_i,
  output lca_pkg::cmd_t cmd_o
);

  lca_pkg::ctrl_state_e state_q, state_d;
  logic [lca_pkg::SlotW-1:0] idx_q, idx_d;
  logic out_valid_q, out_valid_d;
  logic in_xfer, out_free, finish;

  assign in_stall_o = (state_q != lca_pkg::ST_ACCEPT);
  assign in_xfer = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign finish = sts_i.hit || sts_i.total_zero || (idx_q == lca_pkg::LastTestIdx);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lca_pkg::ST_ACCEPT;
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o = '0;
    cmd_o.test_idx = idx_q;
    case (state_q)
      lca_pkg::ST_ACCEPT: begin
        cmd_o.accum = in_xfer;
        if (in_xfer && in_last_i) begin
          cmd_o.capture_last = 1'b1;
          idx_d = '0;
          state_d = lca_pkg::ST_TEST;
        end
      end
      lca_pkg::ST_TEST: begin
        if (finish) begin
          cmd_o.latch_dom = 1'b1;
          state_d = lca_pkg::ST_EMIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      lca_pkg::ST_EMIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = lca_pkg::ST_ACCEPT;
        end
      end
      default: begin
        state_d = lca_pkg::ST_ACCEPT;
      end
    endcase
  end

  a_last_starts_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_last_i) |=> (state_q == lca_pkg::ST_TEST && idx_q == '0))
    else $error("last transfer did not start share test");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lca_pkg::ST_TEST) |-> (idx_q <= lca_pkg::LastTestIdx))
    else $error("share test index out of range");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lca_pkg::ST_EMIT && out_free) |=>
      (state_q == lca_pkg::ST_ACCEPT && out_valid_q))
    else $error("result not loaded on free output");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lca_pkg::ST_ACCEPT) |-> !cmd_o.accum)
    else $error("accumulate outside accept state");

endmodule

@@ rtl/lca_dpath.sv @@
// Datapath: class sums, thresholds, share compare and result register.
module lca_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lca_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lca_pkg::CfgDataW-1:0] cfg_data_i,
  input  lca_pkg::in_t                 in_data_i,
  input  lca_pkg::cmd_t                cmd_i,
  output lca_pkg::sts_t                sts_o,
  output lca_pkg::out_t                out_data_o
);

  logic [63:0] sums_q [lca_pkg::NumSlots];
  logic tracing_q;
  logic [lca_pkg::ThrW-1:0] total_thr_q, phase_thr_q, cfg_thr;
  logic phase_slow_q, tot_slow_q, total_zero_q;
  logic [69:0] tot60_q;
  logic [2:0] dom_q, dom_d;
  lca_pkg::out_t out_q;
  lca_pkg::slot_sel_t sel;
  logic [63:0] test_sum;
  logic [70:0] sum100;
  logic [69:0] tot_ext;
  logic hit;

  assign cfg_thr = lca_pkg::ThrW'(cfg_data_i) * lca_pkg::ThrW'(lca_pkg::NsPerMs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracing_q <= 1'b0;
      total_thr_q <= '0;
      phase_thr_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lca_pkg::CfgTracing:   tracing_q <= cfg_data_i[0];
        lca_pkg::CfgSlowTotal: total_thr_q <= cfg_thr;
        lca_pkg::CfgSlowPhase: phase_thr_q <= cfg_thr;
        default: ;
      endcase
    end
  end

  assign sel = lca_pkg::slot_of_class(in_data_i.span_class);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lca_pkg::NumSlots; i++) sums_q[i] <= '0;
      phase_slow_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      for (int i = 0; i < lca_pkg::NumSlots; i++) sums_q[i] <= '0;
      phase_slow_q <= 1'b0;
    end else if (cmd_i.accum && in_data_i.span_present) begin
      if (sel.summed) begin
        sums_q[sel.slot] <= sums_q[sel.slot] + in_data_i.span_duration_ns;
      end
      if (in_data_i.span_duration_ns >= 64'(phase_thr_q)) begin
        phase_slow_q <= 1'b1;
      end
    end
  end

  assign tot_ext = 70'(in_data_i.record_total_ns);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_last) begin
      tot60_q <= (tot_ext << 6) - (tot_ext << 2);
      total_zero_q <= (in_data_i.record_total_ns == '0);
      tot_slow_q <= (in_data_i.record_total_ns >= 64'(total_thr_q));
    end
  end

  assign test_sum = sums_q[lca_pkg::order_slot(cmd_i.test_idx)];
  assign sum100 = (71'(test_sum) << 6) + (71'(test_sum) << 5) + (71'(test_sum) << 2);
  assign hit = (sum100 >= 71'(tot60_q));
  assign sts_o = '{hit: hit, total_zero: total_zero_q};

  always_comb begin
    if (total_zero_q) begin
      dom_d = lca_pkg::ClsUnknown;
    end else if (hit) begin
      dom_d = lca_pkg::order_class(cmd_i.test_idx);
    end else begin
      dom_d = lca_pkg::ClsMixed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_dom) begin
      dom_q <= dom_d;
    end
    if (cmd_i.load_out) begin
      out_q.dominant_class <= dom_q;
      out_q.read_wait_sum_ns <= sums_q[lca_pkg::SlotRead];
      out_q.active_sum_ns <= sums_q[lca_pkg::SlotActive];
      out_q.write_sum_ns <= sums_q[lca_pkg::SlotWrite];
      out_q.queue_sum_ns <= sums_q[lca_pkg::SlotQueue];
      out_q.cache_sum_ns <= sums_q[lca_pkg::SlotCache];
      out_q.is_slow <= tracing_q && (tot_slow_q || phase_slow_q);
    end
  end

  assign out_data_o = out_q;

endmodule

@@ rtl/latency_class_accounting_core.sv @@
// Top level of the latency class accounting block.
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_stall_o   in_data_i  (lca_pkg::in_t)
//  out      output     out_valid_o / out_stall_i out_data_o (lca_pkg::out_t)
//  cfg      input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// A span that is not last stays in accept; the next span transfers in the following cycle.
// A last span leads from accept to share test (one class per cycle, one to five classes,
// via the shared sum*100 versus total*60 comparator), then to emit, which loads the result.
// Reset clears sums, thresholds and the output valid asynchronously.
// Input stalls while a record closes; a stalled output holds its result, and the next
// record's spans still transfer until its own result waits in the emit state.
module latency_class_accounting_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lca_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lca_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  lca_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output lca_pkg::out_t                out_data_o
);

  lca_pkg::cmd_t cmd;
  lca_pkg::sts_t sts;

  lca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_span),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lca_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
